### hw/rtl/deq_pkg.sv
package deq_pkg;

  // Storage geometry
  localparam int unsigned Depth  = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned IdxW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned OccW   = 5;

  // Operation codes
  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_e;

  // Control sequence of one request
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } fsm_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [OccW-1:0]    occupancy;
    logic               is_empty;
    logic               is_full;
    logic               dropped;
  } out_rsp_t;

  // Slot memory access from the controller
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [IdxW-1:0]  raddr_front;
    logic [IdxW-1:0]  raddr_back;
  } mem_req_t;

endpackage

### hw/rtl/deq_mem.sv
module deq_mem import deq_pkg::*; (
  input  logic             clk_i,
  input  mem_req_t         mem_req_i,
  output logic [DataW-1:0] rdata_front_o,
  output logic [DataW-1:0] rdata_back_o
);

  logic [DataW-1:0] slots_q [Depth];
  logic [DataW-1:0] rdata_front_q;
  logic [DataW-1:0] rdata_back_q;

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      slots_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  // Read front and back slots, registered
  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rdata_front_q <= slots_q[mem_req_i.raddr_front];
      rdata_back_q  <= slots_q[mem_req_i.raddr_back];
    end
  end

  assign rdata_front_o = rdata_front_q;
  assign rdata_back_o  = rdata_back_q;

endmodule

### hw/rtl/deq_ctrl.sv
module deq_ctrl import deq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_req_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_rsp_t         out_rsp_o,
  output mem_req_t         mem_req_o,
  input  logic [DataW-1:0] rdata_front_i,
  input  logic [DataW-1:0] rdata_back_i
);

  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] i);
    return (i == IdxW'(Depth - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(Depth - 1) : i - 1'b1;
  endfunction

  fsm_e            state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            dropped_q, dropped_d;
  logic            out_valid_q, out_valid_d;
  out_rsp_t        out_rsp_q;
  logic            accept;
  logic            is_full;
  logic            is_empty;
  logic            load_out;

  assign is_full  = (cnt_q == CntW'(Depth));
  assign is_empty = (cnt_q == '0);
  assign accept   = in_valid_i && (state_q == ST_IDLE);

  // Next state, pointer update and memory access
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q;
    load_out    = 1'b0;
    mem_req_o   = '0;
    mem_req_o.wdata       = DataW'(in_req_i.value);
    mem_req_o.raddr_front = head_q;
    mem_req_o.raddr_back  = idx_prev(tail_q);
    in_stall_o  = (state_q != ST_IDLE);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d   = ST_READ;
          dropped_d = 1'b0;
          unique case (in_req_i.kind)
            KIND_PUSH_FRONT: begin
              if (is_full) begin
                dropped_d = 1'b1;
              end else begin
                head_d          = idx_prev(head_q);
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = idx_prev(head_q);
                cnt_d           = cnt_q + 1'b1;
              end
            end
            KIND_PUSH_BACK: begin
              if (is_full) begin
                dropped_d = 1'b1;
              end else begin
                tail_d          = idx_next(tail_q);
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = tail_q;
                cnt_d           = cnt_q + 1'b1;
              end
            end
            KIND_POP_FRONT: begin
              if (is_empty) begin
                dropped_d = 1'b1;
              end else begin
                head_d = idx_next(head_q);
                cnt_d  = cnt_q - 1'b1;
              end
            end
            KIND_POP_BACK: begin
              if (is_empty) begin
                dropped_d = 1'b1;
              end else begin
                tail_d = idx_prev(tail_q);
                cnt_d  = cnt_q - 1'b1;
              end
            end
            default: begin
              dropped_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        // Fetch the new front and back slots
        mem_req_o.re = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        // Load the result once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; empty deque reads zero values
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rsp_q.front_value <= is_empty ? '0 : 32'(rdata_front_i);
      out_rsp_q.back_value  <= is_empty ? '0 : 32'(rdata_back_i);
      out_rsp_q.occupancy   <= OccW'(cnt_q);
      out_rsp_q.is_empty    <= is_empty;
      out_rsp_q.is_full     <= is_full;
      out_rsp_q.dropped     <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= int'(Depth))
    else $error("element count above depth");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(head_q) + int'(cnt_q) == int'(tail_q)) ||
    (int'(head_q) + int'(cnt_q) == int'(tail_q) + int'(Depth)))
    else $error("head, tail and count disagree");

  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> accept && !dropped_d)
    else $error("slot write outside an accepted push");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RESP)
    else $error("result raised outside response step");

  a_drop_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && dropped_d |=> $stable(cnt_q) && $stable(head_q) && $stable(tail_q))
    else $error("ignored request changed the state");
`endif

endmodule

### hw/rtl/double_ended_queue_top.sv
// Double-ended queue of 16 signed 32-bit entries held in a ring buffer. Each request
// pushes a value at the front or back, or pops from the front or back; every request
// returns one result with the front and back entries after the request (zero when
// empty), the occupancy, empty and full flags, and a dropped flag for a push on a full
// queue or a pop on an empty one, which leave the queue unchanged. In a request, the
// accept cycle updates the pointers and writes the slot, the next cycle reads the
// front and back slots from the slot memory (a registered read), and the response
// step then loads the result register; that step repeats for as long as an
// earlier result is still held in the output register by out_stall_i. in_stall_o is
// high from the cycle after an accept until the result is loaded, so one request is
// in work at a time; a new request is taken while an earlier result still waits in
// the output register.
module double_ended_queue_top import deq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  mem_req_t         mem_req;
  logic [DataW-1:0] rdata_front;
  logic [DataW-1:0] rdata_back;

  // Pointer control, sequencing and result register
  deq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_i      (in_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_rsp_o     (out_rsp_o),
    .mem_req_o     (mem_req),
    .rdata_front_i (rdata_front),
    .rdata_back_i  (rdata_back)
  );

  // Slot storage
  deq_mem u_mem (
    .clk_i         (clk_i),
    .mem_req_i     (mem_req),
    .rdata_front_o (rdata_front),
    .rdata_back_o  (rdata_back)
  );

endmodule
